>>> design/smx_pkg.sv
// smx_pkg: shared types, constants and functions of the stack machine executor
// used by smx_alu and stack_machine_executor_top

package smx_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SIGN_VAL = 64'h8000_0000_0000_0000;

	typedef enum logic [3:0] {
		OP_PUSH = 4'd0,
		OP_POP  = 4'd1,
		OP_IN   = 4'd2,
		OP_MUL  = 4'd3,
		OP_SUB  = 4'd4,
		OP_OUT  = 4'd5,
		OP_ADD  = 4'd6,
		OP_DIV  = 4'd7,
		OP_SQRT = 4'd8,
		OP_HALT = 4'd9
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_HALTED   = 3'd1,
		ST_DIVZERO  = 3'd2,
		ST_UNDER    = 3'd3,
		ST_OVER     = 3'd4,
		ST_NEGROOT  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ALU_MUL  = 2'd0,
		ALU_DIV  = 2'd1,
		ALU_SQRT = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef enum logic [1:0] {
		AS_IDLE = 2'd0,
		AS_RUN  = 2'd1,
		AS_FIN  = 2'd2
	} alu_state_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'd0,
		S_POP  = 3'd1,
		S_POPW = 3'd2,
		S_EXEC = 3'd3,
		S_ALU  = 3'd4,
		S_PUSH = 3'd5,
		S_DONE = 3'd6
	} seq_state_t;

	function automatic logic [63:0] saturate(input logic neg, input logic big,
		input logic [63:0] mag);
		logic [63:0] r;
		if (!neg) begin
			r = (big || mag > MAX_POS) ? MAX_POS : mag;
		end else begin
			r = (big || mag > SIGN_VAL) ? SIGN_VAL : (~mag + 64'd1);
		end
		return r;
	endfunction

	function automatic logic [63:0] magnitude(input logic [63:0] x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

endpackage

>>> design/smx_ram.sv
// smx_ram: generic single-write, single-read synchronous memory
// registered read data, no dependencies

module smx_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/smx_alu.sv
// smx_alu: bit-serial Q32.32 multiply, divide and square root unit
// depends on smx_pkg

module smx_alu import smx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  alu_req_t    req,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] result
);

	alu_state_t state_q, state_d;
	alu_op_t    op_q;
	logic [6:0]  cnt_q;
	logic [64:0] hi_q;
	logic [95:0] lo_q;
	logic [63:0] qr_q;
	logic [63:0] den_q;
	logic        neg_q;
	logic        big_q;

	logic [64:0] mul_sum;
	logic [64:0] div_rem;
	logic        div_ge;
	logic [50:0] sq_rem;
	logic [50:0] sq_trial;
	logic        sq_ge;

	always_comb begin
		mul_sum  = {1'b0, hi_q[63:0]} + (lo_q[0] ? {1'b0, den_q} : 65'd0);
		div_rem  = {hi_q[63:0], lo_q[95]};
		div_ge   = div_rem >= {1'b0, den_q};
		sq_rem   = {hi_q[48:0], lo_q[95:94]};
		sq_trial = {1'b0, qr_q[47:0], 2'b01};
		sq_ge    = sq_rem >= sq_trial;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			AS_IDLE: if (req.start) state_d = AS_RUN;
			AS_RUN:  if (cnt_q == 7'd0) state_d = AS_FIN;
			AS_FIN:  state_d = AS_IDLE;
			default: state_d = AS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == AS_IDLE && req.start) begin
			op_q  <= req.op;
			neg_q <= a[63] ^ b[63];
			big_q <= 1'b0;
			hi_q  <= '0;
			qr_q  <= '0;
			unique case (req.op)
				ALU_MUL: begin
					cnt_q <= 7'd63;
					den_q <= magnitude(a);
					lo_q  <= {32'd0, magnitude(b)};
				end
				ALU_DIV: begin
					cnt_q <= 7'd95;
					den_q <= magnitude(b);
					lo_q  <= {magnitude(a), 32'd0};
				end
				default: begin
					cnt_q <= 7'd47;
					den_q <= '0;
					lo_q  <= {a, 32'd0};
				end
			endcase
		end else if (state_q == AS_RUN) begin
			cnt_q <= cnt_q - 7'd1;
			unique case (op_q)
				ALU_MUL: begin
					hi_q <= {1'b0, mul_sum[64:1]};
					lo_q <= {32'd0, mul_sum[0], lo_q[63:1]};
				end
				ALU_DIV: begin
					lo_q <= {lo_q[94:0], 1'b0};
					qr_q <= {qr_q[62:0], div_ge};
					hi_q <= div_ge ? (div_rem - {1'b0, den_q}) : div_rem;
					if (div_ge && cnt_q[6]) begin
						big_q <= 1'b1;
					end
				end
				default: begin
					lo_q <= {lo_q[93:0], 2'b00};
					qr_q <= {qr_q[62:0], sq_ge};
					hi_q <= {14'd0, sq_ge ? (sq_rem - sq_trial) : sq_rem};
				end
			endcase
		end
	end

	always_comb begin
		done   = (state_q == AS_FIN);
		unique case (op_q)
			ALU_MUL:  result = saturate(neg_q, hi_q[63:32] != 32'd0,
				{hi_q[31:0], lo_q[63:32]});
			ALU_DIV:  result = saturate(neg_q, big_q, qr_q);
			default:  result = qr_q;
		endcase
	end

endmodule

>>> design/stack_machine_executor_top.sv
// stack_machine_executor_top: instruction sequencer, stack memory, registers
// depends on smx_pkg, smx_ram, smx_alu
//
// channel   signals                                     direction
// item      item_valid item_stall opcode reg_sel        in
//           immediate in_value
// result    result_valid result_stall status out_valid  out
//           out_value stack_level
//
// one item at a time; push, pop, add, sub, out and in finish in the sequencer itself
// mul, and div or sqrt with valid operands, wait in S_ALU for the bit-serial unit
// each pop from a non-empty stack passes S_POP then S_POPW for the registered stack memory read
// reset clears stack pointer, registers and halt; stack contents are not cleared
// a waiting result does not block the next item, only the next result

module stack_machine_executor_top import smx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [3:0]  opcode,
	input  logic [2:0]  reg_sel,
	input  logic [63:0] immediate,
	input  logic [63:0] in_value,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic        out_valid,
	output logic [63:0] out_value,
	output logic [6:0]  stack_level
);

	seq_state_t state_q, state_d;

	logic [3:0]      op_q;
	logic [2:0]      sel_q;
	logic [63:0]     imm_q;
	logic [63:0]     inv_q;
	logic [SP_W-1:0] sp_q;
	logic [63:0]     regs_q [4];
	logic            halted_q;
	logic [2:0]      fault_q;
	logic [1:0]      pops_q;
	logic            idx_q;
	logic [63:0]     top_q;
	logic [63:0]     nxt_q;
	logic [63:0]     val_q;
	logic            emit_q;
	logic [63:0]     emit_val_q;

	logic            res_valid_q;
	logic [2:0]      status_q;
	logic            out_valid_q;
	logic [63:0]     out_value_q;
	logic [6:0]      level_q;

	logic            accept;
	logic            stop_op;
	logic [1:0]      npops;
	logic [63:0]     add_s;
	logic [63:0]     add_r;
	logic [63:0]     sub_d;
	logic [63:0]     sub_r;
	logic            sp_empty;
	logic            sp_full;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [63:0]       ram_rdata;
	alu_req_t          alu_req;
	logic              alu_done;
	logic [63:0]       alu_result;

	smx_ram #(
		.WIDTH(64),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (val_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	smx_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (top_q),
		.b      (nxt_q),
		.done   (alu_done),
		.result (alu_result)
	);

	always_comb begin
		accept   = item_valid && !item_stall;
		stop_op  = opcode > OP_HALT - 4'd1;
		sp_empty = (sp_q == '0);
		sp_full  = (sp_q >= SP_W'(STACK_DEPTH));
		unique case (opcode) inside
			OP_POP, OP_OUT, OP_SQRT:         npops = 2'd1;
			OP_MUL, OP_SUB, OP_ADD, OP_DIV:  npops = 2'd2;
			default:                         npops = 2'd0;
		endcase
		add_s = top_q + nxt_q;
		add_r = (!(top_q[63] ^ nxt_q[63]) && (add_s[63] ^ top_q[63]))
			? (top_q[63] ? SIGN_VAL : MAX_POS) : add_s;
		sub_d = top_q - nxt_q;
		sub_r = ((top_q[63] ^ nxt_q[63]) && (sub_d[63] ^ top_q[63]))
			? (top_q[63] ? SIGN_VAL : MAX_POS) : sub_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = (halted_q || stop_op) ? S_DONE : S_POP;
			end
			S_POP: begin
				if (pops_q == 2'd0) state_d = S_EXEC;
				else if (!sp_empty) state_d = S_POPW;
			end
			S_POPW: state_d = S_POP;
			S_EXEC: begin
				unique case (op_q) inside
					OP_PUSH, OP_IN, OP_ADD, OP_SUB: state_d = S_PUSH;
					OP_MUL:  state_d = S_ALU;
					OP_DIV:  state_d = (nxt_q == '0) ? S_DONE : S_ALU;
					OP_SQRT: state_d = top_q[63] ? S_PUSH : S_ALU;
					default: state_d = S_DONE;
				endcase
			end
			S_ALU:  if (alu_done) state_d = S_PUSH;
			S_PUSH: state_d = S_DONE;
			S_DONE: if (!res_valid_q || !result_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		item_stall  = (state_q != S_IDLE);
		ram_raddr   = ADDR_W'(sp_q - SP_W'(1));
		ram_waddr   = ADDR_W'(sp_q);
		ram_we      = (state_q == S_PUSH) && !sp_full;
		alu_req.start = (state_q == S_EXEC) && ((op_q == OP_MUL)
			|| (op_q == OP_DIV && nxt_q != '0) || (op_q == OP_SQRT && !top_q[63]));
		unique case (op_q)
			OP_MUL:  alu_req.op = ALU_MUL;
			OP_DIV:  alu_req.op = ALU_DIV;
			default: alu_req.op = ALU_SQRT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			halted_q    <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) regs_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && accept && !halted_q && stop_op) begin
				halted_q <= 1'b1;
			end
			if (state_q == S_POP && pops_q != 2'd0 && !sp_empty) begin
				sp_q <= sp_q - SP_W'(1);
			end
			if (ram_we) begin
				sp_q <= sp_q + SP_W'(1);
			end
			if (state_q == S_EXEC && op_q == OP_POP && !sel_q[2]) begin
				regs_q[sel_q[1:0]] <= top_q;
			end
			if (state_q == S_DONE && state_d == S_IDLE) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q       <= opcode;
					sel_q      <= reg_sel;
					imm_q      <= immediate;
					inv_q      <= in_value;
					fault_q    <= (halted_q || stop_op) ? ST_HALTED : ST_OK;
					pops_q     <= npops;
					idx_q      <= 1'b0;
					top_q      <= '0;
					nxt_q      <= '0;
					emit_q     <= 1'b0;
					emit_val_q <= '0;
				end
			end
			S_POP: begin
				if (pops_q != 2'd0 && sp_empty) begin
					if (idx_q) nxt_q <= '0;
					else top_q <= '0;
					if (fault_q == ST_OK) fault_q <= ST_UNDER;
					pops_q <= pops_q - 2'd1;
					idx_q  <= 1'b1;
				end
			end
			S_POPW: begin
				if (idx_q) nxt_q <= ram_rdata;
				else top_q <= ram_rdata;
				pops_q <= pops_q - 2'd1;
				idx_q  <= 1'b1;
			end
			S_EXEC: begin
				case (op_q)
					OP_PUSH: val_q <= sel_q[2] ? imm_q : regs_q[sel_q[1:0]];
					OP_IN:   val_q <= inv_q;
					OP_ADD:  val_q <= add_r;
					OP_SUB:  val_q <= sub_r;
					OP_OUT: begin
						emit_q     <= 1'b1;
						emit_val_q <= top_q;
					end
					OP_DIV: begin
						if (nxt_q == '0 && fault_q == ST_OK) fault_q <= ST_DIVZERO;
					end
					OP_SQRT: begin
						if (top_q[63]) begin
							val_q <= '0;
							if (fault_q == ST_OK) fault_q <= ST_NEGROOT;
						end
					end
					default: ;
				endcase
			end
			S_ALU: begin
				if (alu_done) val_q <= alu_result;
			end
			S_PUSH: begin
				if (sp_full && fault_q == ST_OK) fault_q <= ST_OVER;
			end
			S_DONE: begin
				if (state_d == S_IDLE) begin
					status_q    <= fault_q;
					out_valid_q <= emit_q;
					out_value_q <= emit_val_q;
					level_q     <= 7'(sp_q);
				end
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign status       = status_q;
	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign stack_level  = level_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second transfer taken while an item is in work");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

	a_alu_push: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> state_q == S_ALU)
		else $error("arithmetic unit finished outside its wait state");

endmodule
